>>> rtl/core/prst_pkg.sv
package prst_pkg;

  localparam int COORD_W  = 10;
  localparam int PROW_W   = 9;
  localparam int FRAC_W   = 16;
  localparam int QUO_W    = COORD_W + FRAC_W;
  localparam int ACC_W    = QUO_W + 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_EDGE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_LEFT  = 1'd1;

  localparam logic [COORD_W-1:0] LEFT_MARGIN_RST = 10'd0;
  localparam logic [COORD_W-1:0] EMPTY_LEFT_RST  = 10'd640;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] edge_x_first;
    logic [COORD_W-1:0] edge_y_first;
    logic [COORD_W-1:0] edge_x_second;
    logic [COORD_W-1:0] edge_y_second;
    logic [COORD_W-1:0] point_col;
    logic [PROW_W-1:0]  point_row;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic [COORD_W-1:0] row_left;
    logic [COORD_W-1:0] row_right;
  } out_item_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_DIV,
    S_WALK,
    S_DRAIN,
    S_QRY,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/prst_if.sv
interface prst_in_if;
  import prst_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prst_out_if;
  import prst_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/prst_div.sv
module prst_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [prst_pkg::QUO_W-1:0]          dividend,
  input  logic [prst_pkg::COORD_W-1:0]        divisor,
  output logic                                done,
  output logic [prst_pkg::QUO_W-1:0]          quotient
);
  import prst_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [QUO_W-1:0]    q_r;
  logic [COORD_W-1:0]  rem_r;
  logic [COORD_W-1:0]  dvs_r;
  logic [COORD_W:0]    shift;
  logic                ge;
  logic [COORD_W:0]    diff;

  assign shift = {rem_r, q_r[QUO_W-1]};
  assign ge    = shift >= {1'b0, dvs_r};
  assign diff  = shift - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[QUO_W-2:0], ge};
      rem_r <= ge ? diff[COORD_W-1:0] : shift[COORD_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> rtl/core/polygon_row_span_table_unit.sv
// channel   dir   payload                                        role
// in_chan   in    mode, edge endpoints, point_col, point_row     clear / edge / query item
// out_chan  out   inside_res, row_left, row_right                one result per item
// cfg_*     in    cfg_we, cfg_idx, cfg_data                      left_margin, empty_left
// clear: one table row written per cycle
// edge: walks one to ROWS rows, after the serial slope divider when the endpoints differ
//   in row; the walk reads and updates one row per cycle
// query: the row is read through the registered table read
// after reset a clearing pass over all ROWS rows runs before the first item is taken
// the result register holds a stalled result while the next item is taken and worked on
module polygon_row_span_table_unit #(
  parameter int ROWS = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  prst_in_if.sink                             in_chan,
  prst_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [prst_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [prst_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import prst_pkg::*;

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = ($clog2(ROWS + 1) > COORD_W) ? $clog2(ROWS + 1) : COORD_W;
  localparam logic [CW-1:0] ROWS_C = CW'(ROWS);
  localparam logic [CW-1:0] ROWS_LAST = CW'(ROWS - 1);
  localparam int MW = 2 * COORD_W;

  state_t state_r, state_nxt;

  logic [COORD_W-1:0] left_margin_r;
  logic [COORD_W-1:0] empty_left_r;

  logic [MW-1:0]      mem [ROWS];
  logic [MW-1:0]      rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [MW-1:0]      mem_wdata;
  logic [AW-1:0]      mem_raddr;

  logic [AW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] yend_r, yend_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] slope_r, slope_nxt;
  logic               neg_r, neg_nxt;

  logic               p_valid_r, p_valid_nxt;
  logic [AW-1:0]      p_idx_r, p_idx_nxt;
  logic [QUO_W-1:0]   p_acc_r, p_acc_nxt;

  logic               q_ok_r, q_ok_nxt;
  logic [COORD_W-1:0] q_col_r, q_col_nxt;

  logic               res_inside_r, res_inside_nxt;
  logic [COORD_W-1:0] res_left_r, res_left_nxt;
  logic [COORD_W-1:0] res_right_r, res_right_nxt;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               out_load;

  logic               accept;
  logic               swap;
  logic [COORD_W-1:0] xa, ya, xb, yb, dxmag, dy;
  logic               dxneg;
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   div_q;

  logic [CW-1:0]      row_ext;
  logic               row_in;
  logic               row_last;
  logic [CW-1:0]      qrow_ext;

  logic [COORD_W-1:0] lb, rb, pval, new_l, new_r;
  logic [COORD_W:0]   lb_m;

  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data = out_data_r;

  assign swap  = in_chan.data.edge_y_second < in_chan.data.edge_y_first;
  assign xa    = swap ? in_chan.data.edge_x_second : in_chan.data.edge_x_first;
  assign ya    = swap ? in_chan.data.edge_y_second : in_chan.data.edge_y_first;
  assign xb    = swap ? in_chan.data.edge_x_first : in_chan.data.edge_x_second;
  assign yb    = swap ? in_chan.data.edge_y_first : in_chan.data.edge_y_second;
  assign dxneg = xb < xa;
  assign dxmag = dxneg ? (xa - xb) : (xb - xa);
  assign dy    = yb - ya;

  assign row_ext  = CW'(row_r);
  assign row_in   = row_ext < ROWS_C;
  assign row_last = (row_r == yend_r) || (row_ext >= ROWS_LAST);
  assign qrow_ext = CW'(in_chan.data.point_row);

  // table row update from the registered read
  assign lb    = rd_data_r[MW-1:COORD_W];
  assign rb    = rd_data_r[COORD_W-1:0];
  assign pval  = p_acc_r[QUO_W-1:FRAC_W];
  assign new_l = (p_acc_r < {lb, {FRAC_W{1'b0}}}) ? pval : lb;
  assign new_r = (p_acc_r > {rb, {FRAC_W{1'b0}}}) ? pval : rb;
  assign lb_m  = {1'b0, lb} + {1'b0, left_margin_r};

  prst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dxmag, {FRAC_W{1'b0}}}),
    .divisor  (dy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_margin_r <= LEFT_MARGIN_RST;
      empty_left_r  <= EMPTY_LEFT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LEFT_MARGIN: left_margin_r <= cfg_data[COORD_W-1:0];
        CFG_EMPTY_LEFT:  empty_left_r  <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_idx_r   <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    yend_r       <= yend_nxt;
    acc_r        <= acc_nxt;
    slope_r      <= slope_nxt;
    neg_r        <= neg_nxt;
    p_idx_r      <= p_idx_nxt;
    p_acc_r      <= p_acc_nxt;
    q_ok_r       <= q_ok_nxt;
    q_col_r      <= q_col_nxt;
    res_inside_r <= res_inside_nxt;
    res_left_r   <= res_left_nxt;
    res_right_r  <= res_right_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    row_nxt        = row_r;
    yend_nxt       = yend_r;
    acc_nxt        = acc_r;
    slope_nxt      = slope_r;
    neg_nxt        = neg_r;
    p_valid_nxt    = 1'b0;
    p_idx_nxt      = p_idx_r;
    p_acc_nxt      = p_acc_r;
    q_ok_nxt       = q_ok_r;
    q_col_nxt      = q_col_r;
    res_inside_nxt = res_inside_r;
    res_left_nxt   = res_left_r;
    res_right_nxt  = res_right_r;
    out_data_nxt   = out_data_r;
    out_load       = 1'b0;
    div_start      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = clr_idx_r;
    mem_wdata      = {empty_left_r, {COORD_W{1'b0}}};
    mem_raddr      = row_ext[AW-1:0];

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {EMPTY_LEFT_RST, {COORD_W{1'b0}}};
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == ROWS_LAST[AW-1:0]) begin
          clr_idx_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = qrow_ext[AW-1:0];
        if (accept) begin
          res_inside_nxt = 1'b0;
          res_left_nxt   = '0;
          res_right_nxt  = '0;
          case (in_chan.data.mode)
            MODE_CLEAR: begin
              clr_idx_nxt = '0;
              state_nxt   = S_CLR;
            end
            MODE_EDGE: begin
              row_nxt   = ya;
              yend_nxt  = yb;
              acc_nxt   = ACC_W'($signed({2'b00, xa, {FRAC_W{1'b0}}}));
              neg_nxt   = dxneg;
              slope_nxt = '0;
              if (dy == '0) begin
                state_nxt = S_WALK;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            MODE_QUERY: begin
              q_ok_nxt  = qrow_ext < ROWS_C;
              q_col_nxt = in_chan.data.point_col;
              state_nxt = S_QRY;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_CLR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == ROWS_LAST[AW-1:0]) begin
          clr_idx_nxt = '0;
          state_nxt   = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          slope_nxt = neg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        p_valid_nxt = row_in;
        p_idx_nxt   = row_ext[AW-1:0];
        p_acc_nxt   = acc_r[QUO_W-1:0];
        acc_nxt     = acc_r + slope_r;
        row_nxt     = row_r + 1'b1;
        if (row_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_QRY: begin
        if (q_ok_r) begin
          res_inside_nxt = (lb < rb) && ({1'b0, q_col_r} > lb_m) && (q_col_r < rb);
          res_left_nxt   = lb;
          res_right_nxt  = rb;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load                = 1'b1;
          out_data_nxt.inside_res = res_inside_r;
          out_data_nxt.row_left   = res_left_r;
          out_data_nxt.row_right  = res_right_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // walk write-back, one row behind the read
    if (p_valid_r) begin
      mem_we    = 1'b1;
      mem_waddr = p_idx_r;
      mem_wdata = {new_l, new_r};
    end

    out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_wb_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (state_r == S_WALK || state_r == S_DRAIN))
    else $error("table write-back outside an edge walk");

  a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> CW'(p_idx_r) < ROWS_C)
    else $error("table write-back beyond the last row");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_chan.ready) |=> state_r == S_DONE)
    else $error("result dropped while the result register was full");

  a_idle_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not return to idle");

endmodule

>>> sim/prst_span_checker.sv
`timescale 1ns / 100ps
module prst_span_checker #(
  parameter int ROWS = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  prst_in_if                              in_mon,
  prst_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [prst_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [prst_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              checked,
  output int                              inside_hits
);
  import prst_pkg::*;

  localparam longint Q_ONE = longint'(1) << FRAC_W;
  localparam int DUE_DEPTH = 8;

  logic [COORD_W-1:0] span_left [ROWS];
  logic [COORD_W-1:0] span_right [ROWS];
  logic [COORD_W-1:0] margin_q;
  logic [COORD_W-1:0] empty_q;
  out_item_t          due_results [DUE_DEPTH];
  int                 due_head;
  int                 due_count;

  function automatic void clear_spans();
    int r;
    for (r = 0; r < ROWS; r++) begin
      span_left[r]  = empty_q;
      span_right[r] = '0;
    end
  endfunction

  function automatic void trace_edge(longint xa, longint ya, longint xb, longint yb);
    longint dx, dy, slope, xq, whole, tmp, row;
    if (yb < ya) begin
      tmp = ya; ya = yb; yb = tmp;
      tmp = xa; xa = xb; xb = tmp;
    end
    dx = xb - xa;
    dy = yb - ya;
    if (dy != 0) begin
      slope = ((dx < 0) ? -dx : dx) * Q_ONE / dy;
      if (dx < 0) slope = -slope;
    end else begin
      slope = dx * Q_ONE;
    end
    xq = xa * Q_ONE;
    for (row = ya; row <= yb; row++) begin
      if (row < ROWS) begin
        whole = (xq >= 0) ? (xq >>> FRAC_W) : -((-xq) >>> FRAC_W);
        if (xq < longint'(span_left[row]) * Q_ONE) span_left[row] = whole[COORD_W-1:0];
        if (xq > longint'(span_right[row]) * Q_ONE) span_right[row] = whole[COORD_W-1:0];
      end
      xq += slope;
    end
  endfunction

  function automatic out_item_t predict_span(in_item_t it);
    out_item_t r;
    int        lb, rb, col;
    r = '0;
    case (it.mode)
      MODE_CLEAR: clear_spans();
      MODE_EDGE: trace_edge(it.edge_x_first, it.edge_y_first,
                            it.edge_x_second, it.edge_y_second);
      MODE_QUERY: begin
        if (it.point_row < ROWS) begin
          lb = span_left[it.point_row];
          rb = span_right[it.point_row];
          col = it.point_col;
          r.inside_res = (lb < rb) && (col > lb + margin_q) && (col < rb);
          r.row_left = span_left[it.point_row];
          r.row_right = span_right[it.point_row];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    int        slot;
    if (!rst_n) begin
      margin_q = LEFT_MARGIN_RST;
      empty_q = EMPTY_LEFT_RST;
      clear_spans();
      due_head = 0;
      due_count = 0;
      mismatches = 0;
      checked = 0;
      inside_hits = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (due_count == 0) begin
          $error("result with nothing outstanding: %p", got);
          mismatches++;
        end else begin
          want = due_results[due_head];
          due_head = (due_head + 1) % DUE_DEPTH;
          due_count--;
          checked++;
          if (want.inside_res) inside_hits++;
          if (got.inside_res !== want.inside_res) begin
            $error("inside_res mismatch: expected %0d actual %0d", want.inside_res,
                   got.inside_res);
            mismatches++;
          end
          if (got.row_left !== want.row_left) begin
            $error("row_left mismatch: expected %0d actual %0d", want.row_left, got.row_left);
            mismatches++;
          end
          if (got.row_right !== want.row_right) begin
            $error("row_right mismatch: expected %0d actual %0d", want.row_right,
                   got.row_right);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (due_count == DUE_DEPTH) begin
          $error("more transactions outstanding than expected: %0d", due_count);
          mismatches++;
        end else begin
          slot = (due_head + due_count) % DUE_DEPTH;
          due_results[slot] = predict_span(in_mon.data);
          due_count++;
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_LEFT_MARGIN: margin_q = cfg_data;
          CFG_EMPTY_LEFT: empty_q = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= due_count;
  end

endmodule

>>> sim/polygon_row_span_table_unit_tb.sv
`timescale 1ns / 100ps
module polygon_row_span_table_unit_tb;
  import prst_pkg::*;

  localparam int ROWS = 512;
  localparam int ITEM_TARGET = 1070;
  localparam int CALM_TAIL = 100;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 600;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches, pending, checked, inside_hits;
  int n_sent, n_clear, n_edge, n_query, n_unused, n_settings;
  int idle_cycles;
  bit tx_idle, rx_idle;

  prst_in_if  in_chan ();
  prst_out_if out_chan ();

  polygon_row_span_table_unit #(.ROWS(ROWS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  prst_span_checker #(.ROWS(ROWS)) span_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked),
    .inside_hits (inside_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side backpressure
  initial begin
    int hold;
    hold = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        hold--;
      end else if (rx_idle && $urandom_range(3) == 0) begin
        out_chan.ready <= 1'b0;
        hold = $urandom_range(8, 1) - 1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL polygon_row_span_table_unit");
    $finish;
  end

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.mode = 2'($urandom_range(3));
    it.edge_x_first = COORD_W'($urandom_range(COORD_MAX));
    it.edge_y_first = COORD_W'($urandom_range(COORD_MAX));
    it.edge_x_second = COORD_W'($urandom_range(COORD_MAX));
    it.edge_y_second = COORD_W'($urandom_range(COORD_MAX));
    it.point_col = COORD_W'($urandom_range(COORD_MAX));
    it.point_row = PROW_W'($urandom_range((1 << PROW_W) - 1));
    return it;
  endfunction

  function automatic in_item_t edge_item(int xa, int ya, int xb, int yb);
    in_item_t it;
    it = rand_item();
    it.mode = MODE_EDGE;
    it.edge_x_first = COORD_W'(xa);
    it.edge_y_first = COORD_W'(ya);
    it.edge_x_second = COORD_W'(xb);
    it.edge_y_second = COORD_W'(yb);
    return it;
  endfunction

  function automatic in_item_t query_item(int col, int row);
    in_item_t it;
    it = rand_item();
    it.mode = MODE_QUERY;
    it.point_col = COORD_W'(col);
    it.point_row = PROW_W'(row);
    return it;
  endfunction

  function automatic in_item_t mode_item(logic [1:0] mode);
    in_item_t it;
    it = rand_item();
    it.mode = mode;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it = rand_item();
    if (it.mode == MODE_EDGE && $urandom_range(3) != 0) begin
      it.edge_y_second = COORD_W'(clip(int'(it.edge_y_first) + $urandom_range(40) - 20,
                                       COORD_MAX));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (tx_idle && $urandom_range(3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= it;
    do @(posedge clk); while (!in_chan.ready);
    n_sent++;
    case (it.mode)
      MODE_CLEAR: n_clear++;
      MODE_EDGE: n_edge++;
      MODE_QUERY: n_query++;
      default: n_unused++;
    endcase
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_regs(int margin, int empty_val);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_LEFT_MARGIN;
    cfg_data <= CFG_DATA_W'(margin);
    @(posedge clk);
    cfg_idx <= CFG_EMPTY_LEFT;
    cfg_data <= CFG_DATA_W'(empty_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic send_polygon(int cx, int cy, int radius,
                              output int xlo, output int xhi, output int ylo, output int yhi);
    int vx [6];
    int vy [6];
    int nv, i, j;
    nv = $urandom_range(6, 3);
    xlo = COORD_MAX; xhi = 0; ylo = COORD_MAX; yhi = 0;
    for (i = 0; i < nv; i++) begin
      vx[i] = clip(cx + $urandom_range(2 * radius) - radius, COORD_MAX);
      vy[i] = clip(cy + $urandom_range(2 * radius) - radius, COORD_MAX);
      if (vx[i] < xlo) xlo = vx[i];
      if (vx[i] > xhi) xhi = vx[i];
      if (vy[i] < ylo) ylo = vy[i];
      if (vy[i] > yhi) yhi = vy[i];
    end
    for (i = 0; i < nv; i++) begin
      j = (i + 1) % nv;
      send_item(edge_item(vx[i], vy[i], vx[j], vy[j]));
    end
  endtask

  initial begin
    int phase, margin, empty_val, radius, cx, cy, row, col;
    int xlo, xhi, ylo, yhi;
    bit calm;
    logic [1:0] style;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_item(query_item(0, 0));
    send_item(query_item(COORD_MAX, ROWS - 1));
    send_item(edge_item(100, 5, 300, 5));
    send_item(query_item(200, 5));
    send_item(edge_item(500, 30, 50, 30));
    send_item(query_item(400, 30));
    send_item(edge_item(400, 20, 200, 10));
    send_item(edge_item(150, 10, 350, 20));
    send_item(query_item(250, 15));
    send_item(query_item(150, 10));
    send_item(query_item(151, 10));
    send_item(edge_item(COORD_MAX, 0, 0, COORD_MAX));
    send_item(edge_item(0, COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(edge_item(COORD_MAX, 600, COORD_MAX, 400));
    send_item(edge_item(0, 0, COORD_MAX, 0));
    send_item(query_item(512, 0));
    send_item(query_item(COORD_MAX, 0));
    send_item(query_item(500, 450));
    send_item(mode_item(MODE_UNUSED));
    send_item(mode_item(MODE_CLEAR));
    send_item(query_item(0, 0));
    send_item(edge_item(7, 3, 9, ROWS - 1));
    send_item(query_item(8, 300));

    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      calm = (n_sent >= ITEM_TARGET - CALM_TAIL);
      drain();
      case (phase)
        0: begin
          margin = COORD_MAX;
          empty_val = 0;
        end
        1: begin
          margin = 0;
          empty_val = COORD_MAX;
        end
        default: begin
          margin = ($urandom_range(4) == 0) ? $urandom_range(COORD_MAX) : $urandom_range(24);
          empty_val = ($urandom_range(2) == 0) ? int'(EMPTY_LEFT_RST)
                                                 : $urandom_range(COORD_MAX);
        end
      endcase
      program_regs(margin, empty_val);
      style = 2'($urandom_range(3));
      tx_idle = !calm && style[0];
      rx_idle = !calm && style[1];

      send_item(mode_item(MODE_CLEAR));
      radius = ($urandom_range(9) == 0) ? $urandom_range(300, 40) : $urandom_range(40, 2);
      cx = $urandom_range(COORD_MAX);
      cy = ($urandom_range(7) == 0) ? $urandom_range(COORD_MAX, 400) : $urandom_range(ROWS - 1);
      send_polygon(cx, cy, radius, xlo, xhi, ylo, yhi);
      repeat ($urandom_range(30, 12)) begin
        if (ylo >= ROWS || $urandom_range(9) == 0) begin
          row = $urandom_range(ROWS - 1);
        end else begin
          row = $urandom_range(clip(yhi, ROWS - 1), ylo);
        end
        col = $urandom_range(clip(xhi + 4, COORD_MAX), clip(xlo - 4, COORD_MAX));
        send_item(query_item(col, row));
      end
      repeat ($urandom_range(4)) send_item(noise_item());
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d clears, %0d edges, %0d queries, %0d unused-mode transactions",
             n_clear, n_edge, n_query, n_unused);
    $display("%0d register settings, %0d results checked, %0d points found inside",
             n_settings, checked, inside_hits);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS polygon_row_span_table_unit");
    end else begin
      $display("FAIL polygon_row_span_table_unit");
    end
    $finish;
  end

endmodule
